/* sv/pmdp_pkg.sv */
`timescale 1ns / 1ps
// shared constants, tables and types for the pixel to mono dither packer
package pmdp_pkg;

	localparam int PANEL_WIDTH  = 400;
	localparam int PANEL_HEIGHT = 300;
	localparam int BYTES_PER_COL = (PANEL_HEIGHT + 3) / 4;
	localparam int IY_W = $clog2(PANEL_HEIGHT);

	localparam int COORD_W = 9;
	localparam int BYTE_W  = 14;

	localparam logic [7:0] LUMA_R = 8'd77;
	localparam logic [7:0] LUMA_G = 8'd150;
	localparam logic [7:0] LUMA_B = 8'd29;

	localparam logic [6:0] CHROMA_GAIN = 7'd112;
	localparam logic [6:0] CHROMA_BIAS = 7'd127;

	localparam logic [7:0] THR_MID   = 8'd128;
	localparam logic [7:0] THR_DARK  = 8'd176;
	localparam logic [7:0] THR_LIGHT = 8'd144;

	localparam logic [2:0] MODE_CLEAR     = 3'd0;
	localparam logic [2:0] MODE_DARK      = 3'd1;
	localparam logic [2:0] MODE_LIGHT     = 3'd2;
	localparam logic [2:0] MODE_PHOTO     = 3'd3;
	localparam logic [2:0] MODE_INVERT    = 3'd4;
	localparam logic [2:0] MODE_INV_PHOTO = 3'd5;

	localparam logic [5:0] BAYER [64] = '{
		6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
		6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
		6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
		6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
		6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
		6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
		6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
		6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
	};

	typedef struct packed {
		logic       on;
		logic [7:0] thr;
	} pos_t;

endpackage

/* sv/pmdp_addr.sv */
`timescale 1ns / 1ps
// coordinate pipeline: panel check, dither threshold, packed byte and bit position
module pmdp_addr (
	input  logic                          clk,
	input  logic [pmdp_pkg::COORD_W-1:0]  col,
	input  logic [pmdp_pkg::COORD_W-1:0]  row,
	output pmdp_pkg::pos_t                pos_s2,
	output logic [pmdp_pkg::BYTE_W-1:0]   byte_s3,
	output logic [2:0]                    bit_s3
);

	logic [pmdp_pkg::COORD_W-2:0] half_s1;
	logic [pmdp_pkg::IY_W-1:0]    iy_s1;
	logic                         col0_s1;
	logic                         on_s1;
	logic [7:0]                   thr_s1;

	logic [pmdp_pkg::BYTE_W-1:0]  byte_s2;
	logic [2:0]                   bit_s2;

	logic [31:0]                  iy_full;
	logic [31:0]                  byte_full;

	assign iy_full = 32'(pmdp_pkg::PANEL_HEIGHT - 1) - 32'(row);
	assign byte_full = 32'(half_s1) * 32'(pmdp_pkg::BYTES_PER_COL)
		+ 32'(iy_s1[pmdp_pkg::IY_W-1:2]);

	always_ff @(posedge clk) begin
		half_s1 <= col[pmdp_pkg::COORD_W-1:1];
		iy_s1   <= iy_full[pmdp_pkg::IY_W-1:0];
		col0_s1 <= col[0];
		on_s1   <= (32'(col) < 32'(pmdp_pkg::PANEL_WIDTH))
			&& (32'(row) < 32'(pmdp_pkg::PANEL_HEIGHT));
		thr_s1  <= {pmdp_pkg::BAYER[{row[2:0], col[2:0]}], 2'b10};

		byte_s2    <= byte_full[pmdp_pkg::BYTE_W-1:0];
		bit_s2     <= 3'd7 - {iy_s1[1:0], col0_s1};
		pos_s2.on  <= on_s1;
		pos_s2.thr <= thr_s1;

		byte_s3 <= pos_s2.on ? byte_s2 : '0;
		bit_s3  <= pos_s2.on ? bit_s2 : '0;
	end

endmodule

/* sv/pmdp_color.sv */
`timescale 1ns / 1ps
// color pipeline: luma, chroma penalty and the black or white decision
module pmdp_color (
	input  logic           clk,
	input  logic [31:0]    pixel,
	input  logic [2:0]     mode,
	input  pmdp_pkg::pos_t pos_s2,
	output logic           white_s3
);

	logic [7:0]  r, g, b, mx, mn;
	logic [15:0] pr_s1, pg_s1, pb_s1;
	logic [7:0]  chroma_s1;

	logic [7:0]  lum_s2;
	logic [14:0] pen_num_s2;

	logic [15:0] sum;
	logic [15:0] pen_tmp;
	logic [7:0]  pen;
	logic        w;

	assign r = pixel[7:0];
	assign g = pixel[15:8];
	assign b = pixel[23:16];

	always_comb begin
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
	end

	assign sum = pr_s1 + pg_s1 + pb_s1;

	// divide by 255 through reciprocal, exact below 65535
	assign pen_tmp = 16'(pen_num_s2) + 16'(pen_num_s2[14:8]) + 16'd1;
	assign pen = pen_tmp[15:8];

	always_comb begin
		unique case (mode)
			pmdp_pkg::MODE_DARK:      w = lum_s2 > pmdp_pkg::THR_DARK;
			pmdp_pkg::MODE_LIGHT:     w = lum_s2 > pmdp_pkg::THR_LIGHT;
			pmdp_pkg::MODE_PHOTO:     w = lum_s2 > pos_s2.thr;
			pmdp_pkg::MODE_INVERT:    w = lum_s2 <= pmdp_pkg::THR_MID;
			pmdp_pkg::MODE_INV_PHOTO: w = lum_s2 <= pos_s2.thr;
			default:                  w = {1'b0, lum_s2} > ({1'b0, pmdp_pkg::THR_MID} + {1'b0, pen});
		endcase
	end

	always_ff @(posedge clk) begin
		pr_s1     <= 16'(r) * 16'(pmdp_pkg::LUMA_R);
		pg_s1     <= 16'(g) * 16'(pmdp_pkg::LUMA_G);
		pb_s1     <= 16'(b) * 16'(pmdp_pkg::LUMA_B);
		chroma_s1 <= mx - mn;

		lum_s2     <= sum[15:8];
		pen_num_s2 <= 15'(chroma_s1) * 15'(pmdp_pkg::CHROMA_GAIN)
			+ 15'(pmdp_pkg::CHROMA_BIAS);

		white_s3 <= pos_s2.on & w;
	end

endmodule

/* sv/pixel_to_mono_dither_packer_unit.sv */
`timescale 1ns / 1ps
// top level of the pixel to mono dither packer
//
// One pixel transfer per clock: start is taken on every cycle (busy stays low) and
// the matching result appears with done in order, after the three register stages
// of the luma, chroma penalty and address datapaths. The receiver cannot stall, so
// each result is valid for one cycle only. Write mode through the cfg channel
// only while no pixel is in flight.
module pixel_to_mono_dither_packer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [31:0]                  pixel,
	input  logic [pmdp_pkg::COORD_W-1:0] col,
	input  logic [pmdp_pkg::COORD_W-1:0] row,
	output logic                         done,
	output logic [pmdp_pkg::BYTE_W-1:0]  byte_index,
	output logic [2:0]                   bit_index,
	output logic                         white,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_data
);

	logic [2:0]     mode_q;
	logic           v_s1, v_s2, v_s3;
	pmdp_pkg::pos_t pos_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pmdp_pkg::MODE_CLEAR;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	pmdp_addr u_addr (
		.clk     (clk),
		.col     (col),
		.row     (row),
		.pos_s2  (pos_s2),
		.byte_s3 (byte_index),
		.bit_s3  (bit_index)
	);

	pmdp_color u_color (
		.clk      (clk),
		.pixel    (pixel),
		.mode     (mode_q),
		.pos_s2   (pos_s2),
		.white_s3 (white)
	);

endmodule

/* sv/pmdp_checker.sv */
`timescale 1ns / 1ps
// port level checker for the pixel to mono dither packer, with its bind
module pmdp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [pmdp_pkg::COORD_W-1:0] col,
	input logic [pmdp_pkg::COORD_W-1:0] row,
	input logic                         done,
	input logic [pmdp_pkg::BYTE_W-1:0]  byte_index,
	input logic [2:0]                   bit_index,
	input logic                         white
);

	// every transfer is followed by its result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("missing result after transfer");

	// no result without a transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3) && !$past(busy, 3))
		else $error("result without transfer");

	// off panel pixels give an all zero result
	a_off_panel: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (32'(col) >= 32'(pmdp_pkg::PANEL_WIDTH)
			|| 32'(row) >= 32'(pmdp_pkg::PANEL_HEIGHT))
		|-> ##3 (done && !white && byte_index == '0 && bit_index == '0))
		else $error("off panel result not cleared");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind pixel_to_mono_dither_packer_unit pmdp_checker u_pmdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.col        (col),
	.row        (row),
	.done       (done),
	.byte_index (byte_index),
	.bit_index  (bit_index),
	.white      (white)
);

/* tb/pixel_to_mono_dither_packer_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the pixel to mono dither packer top level
module pixel_to_mono_dither_packer_unit_tb;

	localparam int PANEL_W         = 400;
	localparam int PANEL_H         = 300;
	localparam int COL_BYTES       = (PANEL_H + 3) / 4;
	localparam int DRAIN_CYCLES    = 8;
	localparam int ITEMS_PER_BLOCK = 77;
	localparam int NUM_MODES       = 8;

	localparam int DITHER_TAB [64] = '{
		0,  48, 12, 60, 3,  51, 15, 63,
		32, 16, 44, 28, 35, 19, 47, 31,
		8,  56, 4,  52, 11, 59, 7,  55,
		40, 24, 36, 20, 43, 27, 39, 23,
		2,  50, 14, 62, 1,  49, 13, 61,
		34, 18, 46, 30, 33, 17, 45, 29,
		10, 58, 6,  54, 9,  57, 5,  53,
		42, 26, 38, 22, 41, 25, 37, 21
	};

	// pixel, col, row
	localparam logic [49:0] DIRECTED [20] = '{
		{32'h0000_0000, 9'd0,   9'd0},
		{32'hFFFF_FFFF, 9'd399, 9'd299},
		{32'h00FF_FFFF, 9'd0,   9'd299},
		{32'hFF00_0000, 9'd399, 9'd0},
		{32'h0000_00FF, 9'd1,   9'd1},
		{32'h0000_FF00, 9'd2,   9'd2},
		{32'h00FF_0000, 9'd3,   9'd3},
		{32'h0080_8080, 9'd4,   9'd5},
		{32'h0081_8181, 9'd5,   9'd4},
		{32'h7F81_8181, 9'd6,   9'd7},
		{32'h0000_FFFF, 9'd7,   9'd6},
		{32'h00C0_FFC0, 9'd100, 9'd150},
		{32'h00B1_B1B1, 9'd398, 9'd298},
		{32'h0090_9090, 9'd398, 9'd1},
		{32'h00FF_FFFF, 9'd400, 9'd0},
		{32'h00FF_FFFF, 9'd0,   9'd300},
		{32'h00FF_FFFF, 9'd511, 9'd511},
		{32'hFFFF_FFFF, 9'd399, 9'd300},
		{32'hFFFF_FFFF, 9'd400, 9'd299},
		{32'h00A0_A0FF, 9'd256, 9'd256}
	};

	typedef struct packed {
		logic [pmdp_pkg::BYTE_W-1:0] byte_idx;
		logic [2:0]                  bit_idx;
		logic                        white;
	} dot_t;

	class dot_predictor;
		logic [2:0] mode;
		dot_t       pending_dots[$];
		int         errors;

		function new();
			mode   = pmdp_pkg::MODE_CLEAR;
			errors = 0;
		endfunction

		function void note_pixel(logic [31:0] p, logic [8:0] c, logic [8:0] r);
			int   cx, cy, red, grn, blu, luma, hi, lo, iy, thr;
			logic lit;
			dot_t d;
			d  = '0;
			cx = c;
			cy = r;
			if (cx < PANEL_W && cy < PANEL_H) begin
				red  = p[7:0];
				grn  = p[15:8];
				blu  = p[23:16];
				luma = (77 * red + 150 * grn + 29 * blu) >> 8;
				hi   = (red > grn) ? red : grn;
				hi   = (hi > blu) ? hi : blu;
				lo   = (red < grn) ? red : grn;
				lo   = (lo < blu) ? lo : blu;
				iy   = PANEL_H - 1 - cy;
				thr  = DITHER_TAB[(cy & 7) * 8 + (cx & 7)] * 4 + 2;
				case (mode)
					pmdp_pkg::MODE_DARK:      lit = luma > 176;
					pmdp_pkg::MODE_LIGHT:     lit = luma > 144;
					pmdp_pkg::MODE_PHOTO:     lit = luma > thr;
					pmdp_pkg::MODE_INVERT:    lit = luma <= 128;
					pmdp_pkg::MODE_INV_PHOTO: lit = luma <= thr;
					default:                  lit = (luma - ((hi - lo) * 112 + 127) / 255) > 128;
				endcase
				d.byte_idx = pmdp_pkg::BYTE_W'((cx >> 1) * COL_BYTES + (iy >> 2));
				d.bit_idx  = 3'(7 - (((iy & 3) << 1) | (cx & 1)));
				d.white    = lit;
			end
			pending_dots.push_back(d);
		endfunction

		function void check_dot(logic [pmdp_pkg::BYTE_W-1:0] byte_idx, logic [2:0] bit_idx,
				logic white);
			dot_t want;
			if (pending_dots.size() == 0) begin
				$error("result with no pixel pending: byte_index %0d bit_index %0d white %0d",
					byte_idx, bit_idx, white);
				errors++;
			end else begin
				want = pending_dots.pop_front();
				if (want.byte_idx !== byte_idx) begin
					$error("byte_index: expected %0d, actual %0d", want.byte_idx, byte_idx);
					errors++;
				end
				if (want.bit_idx !== bit_idx) begin
					$error("bit_index: expected %0d, actual %0d", want.bit_idx, bit_idx);
					errors++;
				end
				if (want.white !== white) begin
					$error("white: expected %0d, actual %0d", want.white, white);
					errors++;
				end
			end
		endfunction
	endclass

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         start     = 1'b0;
	logic                         busy;
	logic [31:0]                  pixel     = '0;
	logic [pmdp_pkg::COORD_W-1:0] col       = '0;
	logic [pmdp_pkg::COORD_W-1:0] row       = '0;
	logic                         done;
	logic [pmdp_pkg::BYTE_W-1:0]  byte_index;
	logic [2:0]                   bit_index;
	logic                         white;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [2:0]                   cfg_data  = '0;

	dot_predictor board = new();

	pixel_to_mono_dither_packer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel      (pixel),
		.col        (col),
		.row        (row),
		.done       (done),
		.byte_index (byte_index),
		.bit_index  (bit_index),
		.white      (white),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			board.check_dot(byte_index, bit_index, white);
		end
	end

	task automatic send_pixel(input logic [31:0] p, input logic [8:0] c, input logic [8:0] r,
			input int idle_pct);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			pixel <= $urandom();
			col   <= 9'($urandom());
			row   <= 9'($urandom());
			@(negedge clk);
		end
		while (!taken) begin
			start <= 1'b1;
			pixel <= p;
			col   <= c;
			row   <= r;
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
				board.note_pixel(p, c, r);
			end
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (board.pending_dots.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [2:0] m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          idle;
		logic [31:0] p;
		logic [7:0]  v;
		logic [8:0]  c, r;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset mode applies here
		foreach (DIRECTED[i]) begin
			send_pixel(DIRECTED[i][49:18], DIRECTED[i][17:9], DIRECTED[i][8:0], 0);
		end

		for (int phase = 0; phase < 3; phase++) begin
			idle = (phase == 0) ? 17 : (phase == 1) ? 51 : 0;
			for (int m = 0; m < NUM_MODES; m++) begin
				write_mode(3'(m));
				repeat (ITEMS_PER_BLOCK) begin
					case ($urandom_range(3))
						0: begin
							// gray near the fixed and dither thresholds
							v = 8'($urandom_range(120, 190));
							p = {8'($urandom()), v, v, v};
						end
						1: begin
							p = {8'($urandom()),
								$urandom_range(1) ? 8'hFF : 8'h00,
								$urandom_range(1) ? 8'hFF : 8'($urandom()),
								$urandom_range(1) ? 8'h00 : 8'($urandom())};
						end
						default: p = $urandom();
					endcase
					if ($urandom_range(9) != 0) begin
						c = 9'($urandom_range(PANEL_W - 1));
						r = 9'($urandom_range(PANEL_H - 1));
					end else begin
						c = 9'($urandom());
						r = 9'($urandom());
					end
					send_pixel(p, c, r, idle);
				end
			end
		end

		wait_drained();
		if (board.errors == 0 && board.pending_dots.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
